// ===== hw/rtl/glcm_pkg.sv =====
// Package for the gcd/lcm unit: widths, operation codes, sequencer states,
// datapath steps and the control/status bundles between sequencer and datapath.
// No dependencies.
`timescale 1ns / 1ps

package glcm_pkg;

    localparam int DATA_W = 64;
    localparam int CNT_W  = $clog2(DATA_W);

    localparam logic OP_GCD = 1'b0;
    localparam logic OP_LCM = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS_A,
        ST_ABS_B,
        ST_TWOS,
        ST_REDUCE,
        ST_SCALE,
        ST_DIV,
        ST_MUL,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        SEL_NEG_U,
        SEL_NEG_V,
        SEL_U_MINUS_V,
        SEL_DIV,
        SEL_MUL,
        SEL_FIN
    } t_alu_sel;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_ABS_U,
        ACT_ABS_V,
        ACT_HALVE_BOTH,
        ACT_HALVE_U,
        ACT_HALVE_V,
        ACT_SUB_U,
        ACT_SWAP,
        ACT_SCALE,
        ACT_DIV,
        ACT_MUL,
        ACT_FINISH
    } t_act;

    typedef struct packed {
        t_alu_sel sel;
        t_act     act;
    } t_ctrl;

    typedef struct packed {
        logic u_zero;
        logic v_zero;
        logic u_lsb;
        logic v_lsb;
        logic ge;
        logic cnt_last;
        logic gcd_only;
    } t_status;

endpackage

// ===== hw/rtl/glcm_addsub.sv =====
// Shared add/subtract unit, one bit wider than the data path.
// Depends on glcm_pkg.
`timescale 1ns / 1ps

module glcm_addsub import glcm_pkg::*; (
    input  logic [DATA_W:0] i_a,
    input  logic [DATA_W:0] i_b,
    input  logic            i_sub,
    output logic [DATA_W:0] o_res,
    output logic            o_carry
);

    logic [DATA_W:0] b_op;

    assign b_op = i_sub ? ~i_b : i_b;
    assign {o_carry, o_res} = {1'b0, i_a} + {1'b0, b_op} + {{(DATA_W + 1){1'b0}}, i_sub};

endmodule

// ===== hw/rtl/glcm_ctrl.sv =====
// Sequencer for the gcd/lcm unit: binary gcd, restoring divide, shift-add multiply.
// Depends on glcm_pkg.
`timescale 1ns / 1ps

module glcm_ctrl import glcm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_ctrl   o_ctrl,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_ABS_A;
                end
            end
            ST_ABS_A: n_state = ST_ABS_B;
            ST_ABS_B: n_state = ST_TWOS;
            ST_TWOS: begin
                if (i_status.u_zero || i_status.v_zero) begin
                    n_state = ST_SCALE;
                end else if (i_status.u_lsb || i_status.v_lsb) begin
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (i_status.u_zero || i_status.v_zero) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: n_state = i_status.gcd_only ? ST_FINISH : ST_DIV;
            ST_DIV: begin
                if (i_status.cnt_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (i_status.u_zero) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl.sel = SEL_U_MINUS_V;
        o_ctrl.act = ACT_NONE;
        o_busy     = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctrl.act = ACT_LOAD;
                end
            end
            ST_ABS_A: begin
                o_ctrl.sel = SEL_NEG_U;
                o_ctrl.act = ACT_ABS_U;
            end
            ST_ABS_B: begin
                o_ctrl.sel = SEL_NEG_V;
                o_ctrl.act = ACT_ABS_V;
            end
            ST_TWOS: begin
                if (!i_status.u_zero && !i_status.v_zero
                        && !i_status.u_lsb && !i_status.v_lsb) begin
                    o_ctrl.act = ACT_HALVE_BOTH;
                end
            end
            ST_REDUCE: begin
                priority if (i_status.u_zero || i_status.v_zero) begin
                    o_ctrl.act = ACT_NONE;
                end else if (!i_status.u_lsb) begin
                    o_ctrl.act = ACT_HALVE_U;
                end else if (!i_status.v_lsb) begin
                    o_ctrl.act = ACT_HALVE_V;
                end else if (i_status.ge) begin
                    o_ctrl.act = ACT_SUB_U;
                end else begin
                    o_ctrl.act = ACT_SWAP;
                end
            end
            ST_SCALE: o_ctrl.act = ACT_SCALE;
            ST_DIV: begin
                o_ctrl.sel = SEL_DIV;
                o_ctrl.act = ACT_DIV;
            end
            ST_MUL: begin
                o_ctrl.sel = SEL_MUL;
                if (!i_status.u_zero) begin
                    o_ctrl.act = ACT_MUL;
                end
            end
            ST_FINISH: begin
                o_ctrl.sel = SEL_FIN;
                o_ctrl.act = ACT_FINISH;
            end
            default: o_busy = 1'b1;
        endcase
    end

endmodule

// ===== hw/rtl/glcm_dp.sv =====
// Datapath of the gcd/lcm unit: operand registers around one shared adder.
// Depends on glcm_pkg and glcm_addsub.
`timescale 1ns / 1ps

module glcm_dp import glcm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    input  logic              i_op,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output t_status           o_status,
    output logic [DATA_W-1:0] o_answer,
    output logic              o_valid
);

    logic [DATA_W-1:0] r_u, n_u;
    logic [DATA_W-1:0] r_v, n_v;
    logic [DATA_W-1:0] r_ma, n_ma;
    logic [DATA_W-1:0] r_mb, n_mb;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_ans, n_ans;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_op, n_op;
    logic              r_neg, n_neg;
    logic              r_strobe, n_strobe;

    logic [DATA_W:0]   alu_a;
    logic [DATA_W:0]   alu_b;
    logic              alu_sub;
    logic [DATA_W:0]   alu_res;
    logic              alu_co;
    logic [DATA_W-1:0] gcd_val;
    logic [DATA_W-1:0] div_shift;

    glcm_addsub u_addsub (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_res   (alu_res),
        .o_carry (alu_co)
    );

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (i_ctrl.sel)
            SEL_NEG_U:     alu_b = {1'b0, r_u};
            SEL_NEG_V:     alu_b = {1'b0, r_v};
            SEL_U_MINUS_V: begin
                alu_a = {1'b0, r_u};
                alu_b = {1'b0, r_v};
            end
            SEL_DIV: begin
                alu_a = {r_rem, r_u[DATA_W-1]};
                alu_b = {1'b0, r_v};
            end
            SEL_MUL: begin
                alu_a   = {1'b0, r_rem};
                alu_b   = {1'b0, r_v};
                alu_sub = 1'b0;
            end
            SEL_FIN: begin
                alu_a   = r_neg ? '0 : {1'b0, r_rem};
                alu_b   = r_neg ? {1'b0, r_rem} : '0;
                alu_sub = r_neg;
            end
            default: alu_sub = 1'b1;
        endcase
    end

    assign gcd_val   = (r_u | r_v) << r_k;
    assign div_shift = {r_rem[DATA_W-2:0], r_u[DATA_W-1]};

    always_comb begin
        n_u      = r_u;
        n_v      = r_v;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_rem    = r_rem;
        n_ans    = r_ans;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_op     = r_op;
        n_neg    = r_neg;
        n_strobe = 1'b0;
        unique case (i_ctrl.act)
            ACT_NONE: n_strobe = 1'b0;
            ACT_LOAD: begin
                n_u   = i_a;
                n_v   = i_b;
                n_op  = i_op;
                n_neg = (i_op == OP_LCM) & (i_a[DATA_W-1] ^ i_b[DATA_W-1]);
                n_k   = '0;
            end
            ACT_ABS_U: begin
                n_u  = r_u[DATA_W-1] ? alu_res[DATA_W-1:0] : r_u;
                n_ma = n_u;
            end
            ACT_ABS_V: begin
                n_v  = r_v[DATA_W-1] ? alu_res[DATA_W-1:0] : r_v;
                n_mb = n_v;
            end
            ACT_HALVE_BOTH: begin
                n_u = r_u >> 1;
                n_v = r_v >> 1;
                n_k = r_k + 1'b1;
            end
            ACT_HALVE_U: n_u = r_u >> 1;
            ACT_HALVE_V: n_v = r_v >> 1;
            ACT_SUB_U:   n_u = {1'b0, alu_res[DATA_W-1:1]};
            ACT_SWAP: begin
                n_u = r_v;
                n_v = r_u;
            end
            ACT_SCALE: begin
                n_v   = gcd_val;
                n_rem = (r_op == OP_LCM) ? '0 : gcd_val;
                n_u   = r_ma;
                n_cnt = '0;
            end
            ACT_DIV: begin
                n_rem = alu_co ? alu_res[DATA_W-1:0] : div_shift;
                n_u   = {r_u[DATA_W-2:0], alu_co};
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_rem = '0;
                    n_v   = r_mb;
                end
            end
            ACT_MUL: begin
                if (r_u[0]) begin
                    n_rem = alu_res[DATA_W-1:0];
                end
                n_u = r_u >> 1;
                n_v = r_v << 1;
            end
            ACT_FINISH: begin
                n_ans    = alu_res[DATA_W-1:0];
                n_strobe = 1'b1;
            end
            default: n_strobe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u   <= n_u;
        r_v   <= n_v;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_rem <= n_rem;
        r_ans <= n_ans;
        r_k   <= n_k;
        r_cnt <= n_cnt;
        r_op  <= n_op;
        r_neg <= n_neg;
    end

    assign o_status.u_zero   = (r_u == '0);
    assign o_status.v_zero   = (r_v == '0);
    assign o_status.u_lsb    = r_u[0];
    assign o_status.v_lsb    = r_v[0];
    assign o_status.ge       = alu_co;
    assign o_status.cnt_last = &r_cnt;
    assign o_status.gcd_only = (r_op == OP_GCD) || (r_ma == '0) || (r_mb == '0);

    assign o_answer = r_ans;
    assign o_valid  = r_strobe;

endmodule

// ===== hw/rtl/gcd_lcm_int64.sv =====
// Top level of the 64-bit gcd/lcm unit: sequencer plus shared-adder datapath.
// Depends on glcm_pkg, glcm_ctrl and glcm_dp.
//
//   channel | ports                                  | transfer when
//   --------+----------------------------------------+-------------------------
//   command | start, i_op, i_operand_a, i_operand_b  | start && !busy
//   result  | o_valid, o_answer                      | o_valid (one cycle)
//
// One item runs through the load and abs steps, the binary gcd loop on the shared adder
// (one halving, swap or subtract per cycle), the scale step, then for lcm the restoring
// divide steps and the shift-add multiply steps plus an exit step, and last a step that
// signs the result. busy is high from the transfer until the result strobe; the strobe
// cycle already accepts the next command. Synchronous reset returns to idle.
// The result side cannot stall.
`timescale 1ns / 1ps

module gcd_lcm_int64 import glcm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_op,
    input  logic signed [DATA_W-1:0] i_operand_a,
    input  logic signed [DATA_W-1:0] i_operand_b,
    output logic signed [DATA_W-1:0] o_answer,
    output logic                     o_valid
);

    t_ctrl             ctrl;
    t_status           status;
    logic [DATA_W-1:0] answer;

    glcm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_busy   (busy)
    );

    glcm_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_op     (i_op),
        .i_a      (i_operand_a),
        .i_b      (i_operand_b),
        .o_status (status),
        .o_answer (answer),
        .o_valid  (o_valid)
    );

    assign o_answer = answer;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    a_idle_at_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_result_follows_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a command in flight");

endmodule
